[hw/rtl/li_pkg.sv]
// Shared types and constants for the line intersection block.
// Used by li_front, li_fifo, li_back and line_intersection.
package li_pkg;

   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = 2 * COEF_WIDTH;
   localparam int DIFF_W     = PROD_W + 1;
   localparam int MAG_W      = PROD_W;
   localparam int NUM_W      = MAG_W + FRAC_BITS;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] first_a;
      logic signed [COEF_WIDTH-1:0] first_b;
      logic signed [COEF_WIDTH-1:0] first_c;
      logic signed [COEF_WIDTH-1:0] second_a;
      logic signed [COEF_WIDTH-1:0] second_b;
      logic signed [COEF_WIDTH-1:0] second_c;
   } req_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] cross_x;
      logic signed [COEF_WIDTH-1:0] cross_y;
      logic                         found;
      logic                         clipped;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic             found;   // determinant nonzero
      logic             same_x;  // numerator x and determinant share sign
      logic             same_y;
      logic [MAG_W-1:0] den;
      logic [MAG_W-1:0] num_x;
      logic [MAG_W-1:0] num_y;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

[hw/rtl/li_front.sv]
// Front end: accepts transactions, forms products, determinant and numerators,
// and classifies them into sign and magnitude. Depends on li_pkg.
module li_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  li_pkg::req_type   in_data,
   output logic              out_valid,
   output li_pkg::item_type  out_item
);

   localparam int PW = li_pkg::PROD_W;
   localparam int DW = li_pkg::DIFF_W;
   localparam int MW = li_pkg::MAG_W;

   logic              a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   li_pkg::req_type   a_ff;
   logic signed [PW-1:0] p_ff [6];
   logic signed [DW-1:0] det_ff, nx_ff, ny_ff;
   li_pkg::item_type  d_ff, d_in;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (enable) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   // input register, six products, determinant and numerators, item register
   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff    <= in_data;
         p_ff[0] <= PW'(a_ff.first_a) * PW'(a_ff.second_b);
         p_ff[1] <= PW'(a_ff.first_b) * PW'(a_ff.second_a);
         p_ff[2] <= PW'(a_ff.first_c) * PW'(a_ff.second_b);
         p_ff[3] <= PW'(a_ff.first_b) * PW'(a_ff.second_c);
         p_ff[4] <= PW'(a_ff.first_a) * PW'(a_ff.second_c);
         p_ff[5] <= PW'(a_ff.first_c) * PW'(a_ff.second_a);
         det_ff  <= DW'(p_ff[0]) - DW'(p_ff[1]);
         nx_ff   <= DW'(p_ff[2]) - DW'(p_ff[3]);
         ny_ff   <= DW'(p_ff[4]) - DW'(p_ff[5]);
         d_ff    <= d_in;
      end
   end

   // sign and magnitude split
   always_comb begin
      d_in.found  = (det_ff != '0);
      d_in.same_x = (nx_ff[DW-1] == det_ff[DW-1]);
      d_in.same_y = (ny_ff[DW-1] == det_ff[DW-1]);
      d_in.den    = det_ff[DW-1] ? MW'(-det_ff) : MW'(det_ff);
      d_in.num_x  = nx_ff[DW-1]  ? MW'(-nx_ff)  : MW'(nx_ff);
      d_in.num_y  = ny_ff[DW-1]  ? MW'(-ny_ff)  : MW'(ny_ff);
   end

   assign out_valid = d_vld_ff;
   assign out_item  = d_ff;

endmodule

[hw/rtl/li_fifo.sv]
// Short queue between front and back; four entries of item_type.
// Depends on li_pkg.
module li_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  li_pkg::item_type        push_item,
   input  logic                    pop,
   output li_pkg::item_type        head_item,
   output li_pkg::fifo_status_type status
);

   localparam int AW = li_pkg::FIFO_AW;

   li_pkg::item_type mem_ff [li_pkg::FIFO_DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign head_item    = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == (AW+1)'(li_pkg::FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);

endmodule

[hw/rtl/li_back.sv]
// Back end: pipelined restoring dividers for x and y, one quotient bit per
// stage, then sign, saturation and the output register. Depends on li_pkg.
module li_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  li_pkg::item_type  in_item,
   output logic              in_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output li_pkg::rsp_type   rsp_data
);

   localparam int CW = li_pkg::COEF_WIDTH;
   localparam int MW = li_pkg::MAG_W;
   localparam int NW = li_pkg::NUM_W;
   localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic          found;
      logic          same_x;
      logic          same_y;
      logic          ovf_x;
      logic          ovf_y;
      logic [MW-1:0] den;
      logic [MW-1:0] rx;
      logic [MW-1:0] ry;
      logic [CW-1:0] lx;
      logic [CW-1:0] ly;
      logic [CW-1:0] qx;
      logic [CW-1:0] qy;
   } stage_type;

   logic            en;
   logic [CW:0]     vld_ff;
   stage_type       st_ff [CW+1];
   stage_type       st_in;
   logic [NW-1:0]   nx, ny;
   logic            rsp_valid_ff;
   li_pkg::rsp_type rsp_ff, rsp_in;

   assign en     = !rsp_valid_ff || !rsp_stall;
   assign in_pop = en && in_valid;

   // entry stage: scale numerators, overflow check, initial remainder
   always_comb begin
      nx = NW'(in_item.num_x) << li_pkg::FRAC_BITS;
      ny = NW'(in_item.num_y) << li_pkg::FRAC_BITS;
      st_in.found  = in_item.found;
      st_in.same_x = in_item.same_x;
      st_in.same_y = in_item.same_y;
      st_in.den    = in_item.den;
      st_in.ovf_x  = (NW'(nx[NW-1:CW]) >= NW'(in_item.den));
      st_in.ovf_y  = (NW'(ny[NW-1:CW]) >= NW'(in_item.den));
      st_in.rx     = st_in.ovf_x ? '0 : MW'(nx[NW-1:CW]);
      st_in.ry     = st_in.ovf_y ? '0 : MW'(ny[NW-1:CW]);
      st_in.lx     = nx[CW-1:0];
      st_in.ly     = ny[CW-1:0];
      st_in.qx     = '0;
      st_in.qy     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) st_ff[0] <= st_in;
   end

   // one quotient bit per stage for each coordinate
   for (genvar k = 0; k < CW; k++) begin : g_div
      stage_type     nxt;
      logic [MW:0]   tx, ty;
      logic          gx, gy;

      always_comb begin
         nxt = st_ff[k];
         tx  = {st_ff[k].rx, st_ff[k].lx[CW-1]};
         ty  = {st_ff[k].ry, st_ff[k].ly[CW-1]};
         gx  = (tx >= {1'b0, st_ff[k].den});
         gy  = (ty >= {1'b0, st_ff[k].den});
         nxt.rx = gx ? MW'(tx - {1'b0, st_ff[k].den}) : MW'(tx);
         nxt.ry = gy ? MW'(ty - {1'b0, st_ff[k].den}) : MW'(ty);
         nxt.lx = st_ff[k].lx << 1;
         nxt.ly = st_ff[k].ly << 1;
         nxt.qx = {st_ff[k].qx[CW-2:0], gx};
         nxt.qy = {st_ff[k].qy[CW-2:0], gy};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) st_ff[k+1] <= nxt;
      end
   end

   // sign, saturation and not-found override; an overflowed quotient is
   // never zero, so it takes the sign of the operands
   always_comb begin
      stage_type s;
      logic neg_x, neg_y, clip_x, clip_y;
      s      = st_ff[CW];
      neg_x  = s.same_x && (s.ovf_x || (s.qx != '0));
      neg_y  = s.same_y && (s.ovf_y || (s.qy != '0));
      clip_x = s.ovf_x || (neg_x ? (s.qx > HALF) : (s.qx > HALF - 1'b1));
      clip_y = s.ovf_y || (neg_y ? (s.qy > HALF) : (s.qy > HALF - 1'b1));
      if (!s.found) begin
         rsp_in = '0;
      end else begin
         rsp_in.cross_x = clip_x ? (neg_x ? HALF : HALF - 1'b1)
                                 : (neg_x ? CW'(-s.qx) : s.qx);
         rsp_in.cross_y = clip_y ? (neg_y ? HALF : HALF - 1'b1)
                                 : (neg_y ? CW'(-s.qy) : s.qy);
         rsp_in.found   = 1'b1;
         rsp_in.clipped = clip_x || clip_y;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/line_intersection.sv]
// Line intersection top level: front end, queue and divider back end.
// Depends on li_pkg, li_front, li_fifo and li_back.
//
// Usage:
//   req channel carries two lines a*x+b*y+c=0 as six signed Q16.16
//   coefficients; a transaction is taken when req_valid is high and
//   req_stall is low. rsp channel returns cross_x, cross_y (Q16.16),
//   found and clipped; it is taken when rsp_valid is high and rsp_stall low.
//   Throughput: one transaction per cycle, sustained, while the receiver
//   does not stall. From acceptance to rsp_valid a transaction passes
//   four front stages (input, products, determinant, sign split), the
//   queue, one divider entry stage, one stage per quotient bit, and the
//   output register.
//   When rsp_stall is high with rsp_valid the back pipeline holds; the front keeps taking
//   transactions until the four entry queue fills, then raises req_stall.
//   Parallel or identical lines give found=0 and a zero point; a point
//   outside the Q16.16 range saturates and sets clipped.
//   Reset (synchronous) empties all pipelines and the queue.
module line_intersection (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  li_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output li_pkg::rsp_type rsp_data
);

   li_pkg::fifo_status_type fifo_st;
   li_pkg::item_type        front_item, head_item;
   logic                    front_valid, front_en, push, pop;

   assign front_en  = !fifo_st.full;
   assign req_stall = fifo_st.full;
   assign push      = front_valid && front_en;

   li_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (front_en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   li_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (fifo_st)
   );

   li_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!fifo_st.empty),
      .in_item   (head_item),
      .in_pop    (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[dv/li_checker.sv]
// Checker for line_intersection: watches both channels, predicts each
// crossing point by exact Cramer arithmetic and compares. Depends on li_pkg.
`timescale 1ns / 1ps
module li_checker (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  li_pkg::req_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  li_pkg::rsp_type rsp_data,
   output int              fail_count,
   output int              pending
);
   import li_pkg::*;

   rsp_type expected_points[$];

   // -num/den scaled by 2^FRAC_BITS, truncated toward zero, saturated
   function automatic logic signed [COEF_WIDTH-1:0] solve_coord(
      input logic signed [127:0] num, input logic signed [127:0] den,
      inout logic clip);
      logic signed [127:0] q;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (COEF_WIDTH-1)) - 1;
      lo_lim = -(128'sd1 <<< (COEF_WIDTH-1));
      q = -((num <<< FRAC_BITS) / den);
      if (q > hi_lim) begin
         clip = 1'b1;
         return hi_lim[COEF_WIDTH-1:0];
      end
      if (q < lo_lim) begin
         clip = 1'b1;
         return lo_lim[COEF_WIDTH-1:0];
      end
      return q[COEF_WIDTH-1:0];
   endfunction

   function automatic rsp_type predict_crossing(input req_type r);
      logic signed [127:0] a1, b1, c1, a2, b2, c2, det;
      rsp_type p;
      logic clip;
      a1 = r.first_a;  b1 = r.first_b;  c1 = r.first_c;
      a2 = r.second_a; b2 = r.second_b; c2 = r.second_c;
      det = a1 * b2 - b1 * a2;
      p = '0;
      clip = 1'b0;
      if (det != 0) begin
         p.cross_x = solve_coord(c1 * b2 - b1 * c2, det, clip);
         p.cross_y = solve_coord(a1 * c2 - c1 * a2, det, clip);
         p.found = 1'b1;
         p.clipped = clip;
      end
      return p;
   endfunction

   assign pending = expected_points.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_points.push_back(predict_crossing(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("unexpected transaction: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_points.pop_front();
               if (e.cross_x !== rsp_data.cross_x)
                  $error("cross_x expected %0d actual %0d", e.cross_x, rsp_data.cross_x);
               if (e.cross_y !== rsp_data.cross_y)
                  $error("cross_y expected %0d actual %0d", e.cross_y, rsp_data.cross_y);
               if (e.found !== rsp_data.found)
                  $error("found expected %0d actual %0d", e.found, rsp_data.found);
               if (e.clipped !== rsp_data.clipped)
                  $error("clipped expected %0d actual %0d", e.clipped, rsp_data.clipped);
               if (e !== rsp_data)
                  fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

[dv/testbench.sv]
// Top of the line_intersection testbench: clock, reset, stimulus and verdict.
// Depends on li_pkg, line_intersection and li_checker.
`timescale 1ns / 1ps
module testbench;
   import li_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles = 0;
   bit      stall_on = 1'b0;

   line_intersection dut (.*);
   li_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver stall pattern: runs of stalling and flowing, some long free runs
   always @(posedge clock) begin
      if (stall_on)
         rsp_stall <= ($urandom_range(0, 3) != 0);
      else
         rsp_stall <= 1'b0;
   end
   always @(posedge clock)
      if ($urandom_range(0, 49) == 0) stall_on <= ~stall_on;

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [COEF_WIDTH-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return {1'b0, {(COEF_WIDTH-1){1'b1}}};
         1: return {1'b1, {(COEF_WIDTH-1){1'b0}}};
         2: return '0;
         3: return $urandom_range(0, 3) << FRAC_BITS;
         4: return $signed($urandom_range(0, 400)) - 200;
         default: return $urandom;
      endcase
   endfunction

   // one transaction, held until accepted
   task automatic send_lines(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_coefs(input int a1, b1, c1, a2, b2, c2);
      req_type r;
      r.first_a = a1;  r.first_b = b1;  r.first_c = c1;
      r.second_a = a2; r.second_b = b2; r.second_c = c2;
      send_lines(r);
   endtask

   initial begin
      req_type r;
      int burst;
      int gap;
      localparam int ONE = 1 << FRAC_BITS;
      localparam int MAXV = 32'h7fffffff;
      localparam int MINV = 32'h80000000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: plain crossing, parallel, identical, zero lines
      send_coefs(ONE, 0, -ONE, 0, ONE, -2 * ONE);
      send_coefs(ONE, ONE, 0, 2 * ONE, 2 * ONE, ONE);
      send_coefs(ONE, -ONE, ONE, ONE, -ONE, ONE);
      send_coefs(0, 0, 0, 0, 0, 0);
      // saturation high, low, and truncation toward zero
      send_coefs(1, 0, MINV, 0, 1, MINV);
      send_coefs(1, 0, MAXV, 0, 1, MAXV);
      send_coefs(3, 0, ONE, 0, 3, -ONE);
      send_coefs(7, 1, 5, -3, 11, -9);
      // field extremes
      send_coefs(MINV, MINV, MINV, MINV, MAXV, MINV);
      send_coefs(MAXV, MINV, MAXV, MINV, MAXV, MAXV);
      send_coefs(MAXV, MAXV, MAXV, MAXV, MINV, MINV);
      send_coefs(MINV, 0, MINV, 0, MINV, MAXV);
      send_coefs(-1, 1, -1, 1, 1, 1);
      send_coefs(MAXV, 1, -1, -1, MAXV, 1);
      send_coefs(-ONE, 0, -1, 0, -ONE, 1);
      // random bursts with gaps
      for (int n = 0; n < 1500; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++, n++) begin
            r.first_a = pick_coef(); r.first_b = pick_coef(); r.first_c = pick_coef();
            r.second_a = pick_coef(); r.second_b = pick_coef(); r.second_c = pick_coef();
            if ($urandom_range(0, 9) == 0) begin
               // parallel copy of the first line
               r.second_a = r.first_a;
               r.second_b = r.first_b;
            end
            send_lines(r);
         end
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (3 * (COEF_WIDTH + 6)) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
